// ===== rtl/box_average_downscaler_assert.svh =====
// Assertion macros for the box average downscaler.
// Expect i_clk and i_rst_n in the scope of use.
`ifndef BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALER_ASSERT_SVH

// same-cycle implication
`define BXDS_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define BXDS_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== rtl/bxds_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the box average downscaler.
// No dependencies.
package bxds_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int PIX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 4'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_AMUL,
        S_ADIV,
        S_AWAIT,
        S_OUT,
        S_ADV,
        S_WMUL,
        S_WDIV,
        S_WWAIT
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic rd_en;
        logic acc_we;
        logic mul_area;
        logic mul_win;
        logic div_start;
        logic div_avg;
        logic win_row;
        logic win_load;
        logic first_load;
        logic out_load;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic restart_req;
        logic clr_last;
        logic emit;
        logic adv_col;
        logic adv_row;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/bxds_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on box_average_downscaler_assert.svh.
module bxds_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    `include "box_average_downscaler_assert.svh"

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `BXDS_ASSERT_IMP(a_start_idle, i_start, !r_busy, "divider started while busy")
    `BXDS_ASSERT_NXT(a_done_after_busy, r_busy && (r_cnt == CW'(1)) && !i_start, r_done,
                     "divider missed done")
    `BXDS_ASSERT_IMP(a_done_not_busy, r_done, !r_busy, "divider done while busy")

endmodule

// ===== rtl/bxds_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, column sum memory, counters, multiplier, output register.
// Depends on bxds_pkg, bxds_div and box_average_downscaler_assert.svh.
module bxds_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bxds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bxds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [bxds_pkg::PIX_W-1:0]     i_pix,
    input  bxds_pkg::t_cmd                 i_cmd,
    output bxds_pkg::t_stat                o_stat,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bxds_pkg::PIX_W-1:0]     o_m_tdata,
    output logic                           o_m_tlast,
    output logic                           o_m_tuser
);
    import bxds_pkg::*;
    `include "box_average_downscaler_assert.svh"

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int MW   = (WW > HW) ? WW : HW;
    localparam int PW   = 2 * MW;
    localparam int SUMW = PIX_W + XW + YW;
    localparam int NW   = (SUMW > PW) ? SUMW : PW;

    function automatic logic [31:0] clamp1(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        if (v == 32'd0) res = 32'd1;
        else if (v > hi) res = hi;
        else res = v;
        return res;
    endfunction

    logic [CFG_W-1:0] r_sw, r_sh, r_tw, r_th;
    logic [WW-1:0]    eff_sw, eff_tw;
    logic [HW-1:0]    eff_sh, eff_th;
    logic             cfg_hit;

    logic [XW-1:0]    r_src_col, r_dst_col, r_clr;
    logic [YW-1:0]    r_src_row, r_dst_row;
    logic [WW-1:0]    r_cs, r_ce, r_ce0;
    logic [HW-1:0]    r_rs, r_re, r_re0;

    logic [SUMW-1:0]  r_mem [MAX_WIDTH];
    logic [SUMW-1:0]  r_rdata, r_sum, sum_now;
    logic [PIX_W-1:0] r_pix;
    logic [PW-1:0]    r_prod;
    logic [MW-1:0]    mul_a, mul_b;

    logic [NW-1:0]    div_num, div_den, div_quot;
    logic             div_done;

    logic [WW-1:0]    col_d1, src_c1, ce_new;
    logic [HW-1:0]    row_d1, src_r1, re_new;
    logic             last_c, last_r, col_more, row_more, emit, rd, fd;

    logic             r_ovalid, r_olast, r_ouser;
    logic [PIX_W-1:0] r_opix;

    assign cfg_hit = i_cfg_valid && (i_cfg_index <= REG_TGT_H);

    assign eff_sw = WW'(clamp1(32'(r_sw), 32'(MAX_WIDTH)));
    assign eff_sh = HW'(clamp1(32'(r_sh), 32'(MAX_HEIGHT)));
    assign eff_tw = WW'(clamp1(32'(r_tw), 32'(eff_sw)));
    assign eff_th = HW'(clamp1(32'(r_th), 32'(eff_sh)));

    assign src_c1   = WW'(r_src_col) + WW'(1);
    assign src_r1   = HW'(r_src_row) + HW'(1);
    assign col_d1   = WW'(r_dst_col) + WW'(1);
    assign row_d1   = HW'(r_dst_row) + HW'(1);
    assign last_c   = src_c1 >= r_ce;
    assign last_r   = src_r1 >= r_re;
    assign col_more = src_c1 < eff_sw;
    assign row_more = src_r1 < eff_sh;
    assign emit     = last_c && last_r;
    assign rd       = col_d1 >= eff_tw;
    assign fd       = rd && (row_d1 >= eff_th);

    assign sum_now  = r_rdata + SUMW'(r_pix);

    assign ce_new = (div_quot <= NW'(r_cs)) ? r_cs + WW'(1) : div_quot[WW-1:0];
    assign re_new = (div_quot <= NW'(r_rs)) ? r_rs + HW'(1) : div_quot[HW-1:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= CFG_W'(1);
            r_sh <= CFG_W'(1);
            r_tw <= CFG_W'(1);
            r_th <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC_W: r_sw <= i_cfg_data;
                REG_SRC_H: r_sh <= i_cfg_data;
                REG_TGT_W: r_tw <= i_cfg_data;
                REG_TGT_H: r_th <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position counters and windows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_src_col <= '0;
            r_dst_col <= '0;
            r_src_row <= '0;
            r_dst_row <= '0;
            r_clr     <= '0;
            r_cs      <= '0;
            r_rs      <= '0;
            r_ce      <= WW'(1);
            r_re      <= HW'(1);
            r_ce0     <= WW'(1);
            r_re0     <= HW'(1);
        end else begin
            if (i_cmd.clr_en) r_clr <= r_clr + XW'(1);
            if (i_cmd.win_load) begin
                if (i_cmd.win_row) begin
                    r_re <= re_new;
                    if (i_cmd.first_load) r_re0 <= re_new;
                end else begin
                    r_ce <= ce_new;
                    if (i_cmd.first_load) r_ce0 <= ce_new;
                end
            end
            if (i_cmd.adv) begin
                if (!last_c) begin
                    r_src_col <= r_src_col + XW'(1);
                end else if (col_more) begin
                    r_src_col <= r_src_col + XW'(1);
                    r_dst_col <= r_dst_col + XW'(1);
                    r_cs      <= r_ce;
                end else begin
                    r_src_col <= '0;
                    r_dst_col <= '0;
                    r_cs      <= '0;
                    r_ce      <= r_ce0;
                    if (!last_r) begin
                        r_src_row <= r_src_row + YW'(1);
                    end else if (row_more) begin
                        r_src_row <= r_src_row + YW'(1);
                        r_dst_row <= r_dst_row + YW'(1);
                        r_rs      <= r_re;
                    end else begin
                        r_src_row <= '0;
                        r_dst_row <= '0;
                        r_rs      <= '0;
                        r_re      <= r_re0;
                    end
                end
            end
        end
    end

    // column sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.acc_we) begin
            r_mem[r_dst_col] <= emit ? '0 : sum_now;
        end
        if (i_cmd.rd_en) r_rdata <= r_mem[r_dst_col];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_pix <= i_pix;
        if (i_cmd.acc_we) r_sum <= sum_now;
    end

    // shared multiplier: window area or window end numerator
    always_comb begin
        if (i_cmd.mul_area) begin
            mul_a = MW'(r_ce - r_cs);
            mul_b = MW'(r_re - r_rs);
        end else if (i_cmd.win_row) begin
            mul_a = MW'(row_d1);
            mul_b = MW'(eff_sh);
        end else begin
            mul_a = MW'(col_d1);
            mul_b = MW'(eff_sw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_area || i_cmd.mul_win) r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    assign div_num = i_cmd.div_avg ? NW'(r_sum) : NW'(r_prod);
    assign div_den = i_cmd.div_avg ? NW'(r_prod) :
                     (i_cmd.win_row ? NW'(eff_th) : NW'(eff_tw));

    bxds_div #(
        .W(NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_opix  <= div_quot[PIX_W-1:0];
            r_olast <= rd;
            r_ouser <= fd;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_opix;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

    assign o_stat.restart_req = cfg_hit;
    assign o_stat.clr_last    = (r_clr == XW'(MAX_WIDTH - 1));
    assign o_stat.emit        = emit;
    assign o_stat.adv_col     = last_c && col_more;
    assign o_stat.adv_row     = last_c && !col_more && last_r && row_more;
    assign o_stat.div_done    = div_done;
    assign o_stat.out_free    = !r_ovalid || i_m_tready;

    `BXDS_ASSERT_IMP(a_out_free, i_cmd.out_load, !r_ovalid || i_m_tready,
                     "result overwritten while stalled")
    `BXDS_ASSERT_IMP(a_src_col_rng, 1'b1, src_c1 <= eff_sw, "source column out of range")
    `BXDS_ASSERT_IMP(a_dst_col_rng, 1'b1, col_d1 <= eff_tw, "destination column out of range")

endmodule

// ===== rtl/bxds_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences clear pass, accumulate, divide and window updates.
// Depends on bxds_pkg.
module bxds_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  bxds_pkg::t_stat i_stat,
    output bxds_pkg::t_cmd  o_cmd
);
    import bxds_pkg::*;

    t_state r_state, n_state;
    logic   r_init, n_init;
    logic   r_wrow, n_wrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_init  <= 1'b1;
            r_wrow  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_wrow  <= n_wrow;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        n_wrow        = r_wrow;
        o_cmd         = '0;
        o_cmd.win_row = r_wrow;
        o_s_tready    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) n_state = S_WMUL;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_we = 1'b1;
                n_state      = i_stat.emit ? S_AMUL : S_ADV;
            end
            S_AMUL: begin
                o_cmd.mul_area = 1'b1;
                n_state        = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_avg   = 1'b1;
                n_state         = S_AWAIT;
            end
            S_AWAIT: begin
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                if (i_stat.adv_col) begin
                    n_wrow  = 1'b0;
                    n_state = S_WMUL;
                end else if (i_stat.adv_row) begin
                    n_wrow  = 1'b1;
                    n_state = S_WMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WMUL: begin
                o_cmd.mul_win = 1'b1;
                n_state       = S_WDIV;
            end
            S_WDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WWAIT;
            end
            S_WWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.win_load   = 1'b1;
                    o_cmd.first_load = r_init;
                    if (r_init && !r_wrow) begin
                        n_wrow  = 1'b1;
                        n_state = S_WMUL;
                    end else begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (i_stat.restart_req) begin
            n_state = S_CLEAR;
            n_init  = 1'b1;
            n_wrow  = 1'b0;
        end
    end

endmodule

// ===== rtl/box_average_downscaler.sv =====
`timescale 1ns / 1ps
// Top level of the box average downscaler: controller plus datapath.
// Depends on bxds_pkg, bxds_ctrl and bxds_dp.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------
//  s        | in        | tdata: pixel_in[7:0]
//  m        | out       | tdata: pixel_out[7:0], tlast: row_done,
//           |           | tuser: frame_done
//  cfg      | in        | index: register, data: 13-bit value
//
// A pixel without result runs S_IDLE, S_ACC, S_ADV (plus S_WMUL, S_WDIV, S_WWAIT
// when a column or row window advances). A pixel closing a window adds S_AMUL,
// S_ADIV, S_AWAIT, S_OUT for the area divide through the shared divider and output
// load. After reset or any register write a clear pass over all MAX_WIDTH column
// sums runs, then two window-end divides; no pixel is taken meanwhile. A stalled
// output holds the controller only when the next result is ready to load.
module box_average_downscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bxds_pkg::PIX_W-1:0]     i_s_tdata,   // [7:0] pixel_in
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bxds_pkg::PIX_W-1:0]     o_m_tdata,   // [7:0] pixel_out
    output logic                           o_m_tlast,
    output logic                           o_m_tuser,   // [0] frame_done
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bxds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bxds_pkg::CFG_W-1:0]     i_cfg_data
);
    import bxds_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    bxds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bxds_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
